// ----- sv/tsrb_pkg.sv -----
// Package: shared types and codes for the timestamp sorted record buffer
package tsrb_pkg;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_DEC    = 3'd3,
        OP_QUERY  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOKEY   = 2'd1,
        ST_BADCOL  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_APPLY,
        S_EMIT,
        S_READ
    } t_state;

    // Per-cycle command driven into every cell of the row chain
    typedef enum logic [2:0] {
        C_NONE,
        C_INSERT,
        C_UPDATE,
        C_REMOVE,
        C_DEC
    } t_cmd;

    localparam int unsigned REG_NUM_COLUMNS = 0;
    localparam int unsigned REG_WINDOW_SIZE = 1;

endpackage

// ----- sv/tsrb_if.sv -----
// Interface: valid/ready channel carrying one payload word
interface tsrb_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tsrb_cell.sv -----
// One row cell: key, column values, valid bits, counter and update count
module tsrb_cell
    import tsrb_pkg::*;
#(
    parameter int unsigned COLS = 8,
    parameter int unsigned CW   = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_sel,        // this row is the target
    input  logic                   i_ins_here,   // insert target
    input  logic                   i_ins_shift,  // take row from lower neighbour
    input  logic                   i_rm_shift,   // take row from upper neighbour
    input  logic                   i_in_window,
    input  logic [63:0]            i_key,
    input  logic [CW-1:0]          i_col,
    input  logic [63:0]            i_val,
    // neighbours
    input  logic [63:0]            i_lo_key,
    input  logic [COLS-1:0][63:0]  i_lo_vals,
    input  logic [COLS-1:0]        i_lo_vld,
    input  logic [3:0]             i_lo_cnt,
    input  logic [15:0]            i_lo_upd,
    input  logic [63:0]            i_hi_key,
    input  logic [COLS-1:0][63:0]  i_hi_vals,
    input  logic [COLS-1:0]        i_hi_vld,
    input  logic [3:0]             i_hi_cnt,
    input  logic [15:0]            i_hi_upd,
    output logic [63:0]            o_key,
    output logic [COLS-1:0][63:0]  o_vals,
    output logic [COLS-1:0]        o_vld,
    output logic [3:0]             o_cnt,
    output logic [15:0]            o_upd,
    output logic                   o_match
);
    logic [63:0]           r_key, n_key;
    logic [COLS-1:0][63:0] r_vals, n_vals;
    logic [COLS-1:0]       r_vld, n_vld;
    logic [3:0]            r_cnt, n_cnt;
    logic [15:0]           r_upd, n_upd;

    assign o_key   = r_key;
    assign o_vals  = r_vals;
    assign o_vld   = r_vld;
    assign o_cnt   = r_cnt;
    assign o_upd   = r_upd;
    assign o_match = (r_key == i_key);

    // next row contents
    always_comb begin
        n_key  = r_key;
        n_vals = r_vals;
        n_vld  = r_vld;
        n_cnt  = r_cnt;
        n_upd  = r_upd;
        case (i_cmd)
            C_INSERT: begin
                if (i_ins_here) begin
                    n_key  = i_key;
                    n_vld  = '0;
                    n_vld[i_col]  = 1'b1;
                    n_vals[i_col] = i_val;
                    n_cnt  = {3'd0, i_in_window};
                    n_upd  = 16'd1;
                end else if (i_ins_shift) begin
                    n_key  = i_lo_key;
                    n_vals = i_lo_vals;
                    n_vld  = i_lo_vld;
                    n_cnt  = i_lo_cnt;
                    n_upd  = i_lo_upd;
                end
            end
            C_UPDATE: begin
                if (i_sel) begin
                    if (!r_vld[i_col] && i_in_window && r_cnt != 4'd15)
                        n_cnt = r_cnt + 4'd1;
                    n_vals[i_col] = i_val;
                    n_vld[i_col]  = 1'b1;
                    if (r_upd != 16'hFFFF)
                        n_upd = r_upd + 16'd1;
                end
            end
            C_REMOVE: begin
                if (i_rm_shift) begin
                    n_key  = i_hi_key;
                    n_vals = i_hi_vals;
                    n_vld  = i_hi_vld;
                    n_cnt  = i_hi_cnt;
                    n_upd  = i_hi_upd;
                end
            end
            C_DEC: begin
                if (i_sel && r_cnt != 4'd0)
                    n_cnt = r_cnt - 4'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
            r_upd <= '0;
        end else begin
            r_vld <= n_vld;
            r_cnt <= n_cnt;
            r_upd <= n_upd;
        end
        r_key  <= n_key;
        r_vals <= n_vals;
    end
endmodule

// ----- sv/timestamp_sorted_record_buffer.sv -----
// Top level: sorted record buffer built from a chain of row cells
//
// Input channel i_cmd carries one operation word (opcode, timestamp, column,
// value); output channel o_res carries result words, the final one with last.
// The user must write configuration through i_cfg_we / i_cfg_idx / i_cfg_data
// only while idle; the block itself does not enforce this. An operation is
// taken in the idle state; the rows are searched in the evict state, the cell
// chain applies it to all rows in parallel in the apply state, then its result
// is emitted. A write of a new key into a full table first evicts all leading
// zero-counter rows, one row per cycle. A read emits one word per column in use.
// A new operation is taken only after the last result word of the previous
// one has been accepted. Reset clears all valid bits, counters, update counts
// and the row count; keys and values are undefined until written. When the
// receiver stalls, the pending result word holds and no new operation is taken.
module timestamp_sorted_record_buffer
    import tsrb_pkg::*;
#(
    parameter int unsigned MAX_ROWS      = 64,
    parameter int unsigned MAX_COLUMNS   = 8,
    parameter int unsigned LENGTH_FACTOR = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    tsrb_if.sink        i_cmd,
    tsrb_if.source      o_res
);
    localparam int unsigned RW = $clog2(MAX_ROWS + 1);
    localparam int unsigned IW = $clog2(MAX_ROWS);
    localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // configuration
    logic [3:0] r_ncols;
    logic [5:0] r_win;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncols <= 4'd8;
            r_win   <= 6'd32;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NUM_COLUMNS[0:0]) r_ncols <= i_cfg_data[3:0];
            else r_win <= i_cfg_data;
        end
    end

    logic [7:0] eff_cols;
    logic [6:0] eff_win;
    logic [RW+11:0] cap_raw;
    logic [RW-1:0]  cap;
    always_comb begin
        eff_cols = (r_ncols == 4'd0) ? 8'd1 :
                   ({4'd0, r_ncols} > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : {4'd0, r_ncols};
        eff_win  = (r_win == 6'd0) ? 7'd1 : {1'b0, r_win};
        cap_raw  = (RW+12)'(LENGTH_FACTOR) * (RW+12)'(eff_win);
        cap      = (cap_raw > (RW+12)'(MAX_ROWS)) ? RW'(MAX_ROWS) : cap_raw[RW-1:0];
    end

    // latched operation
    logic [2:0]   r_op;
    logic [63:0]  r_key;
    logic [2:0]   r_col;
    logic [63:0]  r_val;
    logic [RW-1:0] r_rows, n_rows;
    t_state r_st, n_st;
    logic   r_ev_on;

    // cell chain wiring
    logic [MAX_ROWS-1:0][63:0]                  w_key;
    logic [MAX_ROWS-1:0][MAX_COLUMNS-1:0][63:0] w_vals;
    logic [MAX_ROWS-1:0][MAX_COLUMNS-1:0]       w_vld;
    logic [MAX_ROWS-1:0][3:0]                   w_cnt;
    logic [MAX_ROWS-1:0][15:0]                  w_upd;
    logic [MAX_ROWS-1:0]                        w_match;
    logic [MAX_ROWS-1:0] w_hit, w_less, w_sel, w_ins_here, w_ins_shift, w_rm_shift;
    t_cmd w_cmd;

    // registered search results: match vector, index and insert position
    logic [MAX_ROWS-1:0] r_hit;
    logic                r_found;
    logic [IW-1:0]       r_fidx;
    logic [RW-1:0]       r_pos;

    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            w_hit[r]  = w_match[r] && (RW'(r) < r_rows);
            // stored key <= new key : new row goes after it
            w_less[r] = (RW'(r) < r_rows) &&
                        ($signed(w_key[r]) <= $signed(r_key));
        end
    end

    logic [IW-1:0] w_fidx;
    logic [RW-1:0] w_pos;
    always_comb begin
        w_fidx = '0;
        for (int r = 0; r < MAX_ROWS; r++)
            if (w_hit[r]) w_fidx = IW'(r);
        w_pos = RW'($countones(w_less));
    end

    // windows: position p counts when p + win >= rows (rows at time of test)
    logic [RW+7:0] w_upd_wsum, w_ins_wsum;
    logic w_upd_inwin, w_ins_inwin;
    always_comb begin
        w_upd_wsum  = (RW+8)'(r_fidx) + (RW+8)'(eff_win);
        w_upd_inwin = w_upd_wsum >= (RW+8)'(r_rows);
        w_ins_wsum  = (RW+8)'(r_pos) + (RW+8)'(eff_win);
        w_ins_inwin = w_ins_wsum >= (RW+8)'(r_rows + RW'(1));
    end

    // output word
    logic [1:0]  r_o_status;
    logic        r_o_new, r_o_valid, r_o_last, r_o_vld;
    logic [2:0]  r_o_col;
    logic [63:0] r_o_val;
    logic [15:0] r_o_upd;
    logic [7:0]  r_rcol;

    wire out_fire = o_res.valid && o_res.ready;
    // a write of a new key into a full table drops every leading zero-counter row
    wire w_found  = |w_hit;
    wire ev_path  = (r_op == OP_WRITE) && !w_found && ({5'd0, r_col} < eff_cols);
    wire evicting = (r_st == S_EVICT) && ev_path && (r_rows != '0) &&
                    (w_cnt[0] == 4'd0) && ((r_rows >= cap) || r_ev_on);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_cmd.valid) n_st = S_EVICT;
            S_EVICT: if (!evicting) n_st = S_APPLY;
            S_APPLY: n_st = (r_op == OP_READ && r_found) ? S_READ : S_EMIT;
            S_EMIT:  if (out_fire) n_st = S_IDLE;
            S_READ:  if (out_fire && r_o_last) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    wire need_evict_path = (r_op == OP_WRITE) && !r_found &&
                           ({5'd0, r_col} < eff_cols);
    wire ins_ok = need_evict_path && (r_rows < cap);

    // command to the cell chain
    always_comb begin
        w_cmd = C_NONE;
        w_sel = r_hit;
        w_ins_here  = '0;
        w_ins_shift = '0;
        w_rm_shift  = '0;
        case (r_st)
            S_EVICT: if (evicting) begin
                w_cmd = C_REMOVE;
                w_rm_shift = '1;
            end
            S_APPLY: begin
                if (r_op == OP_WRITE && ({5'd0, r_col} < eff_cols)) begin
                    if (r_found) w_cmd = C_UPDATE;
                    else if (ins_ok) begin
                        w_cmd = C_INSERT;
                        for (int r = 0; r < MAX_ROWS; r++) begin
                            w_ins_here[r]  = (RW'(r) == r_pos);
                            w_ins_shift[r] = (RW'(r) > r_pos);
                        end
                    end
                end else if (r_op == OP_DELETE && r_found) begin
                    w_cmd = C_REMOVE;
                    for (int r = 0; r < MAX_ROWS; r++)
                        w_rm_shift[r] = (IW'(r) >= r_fidx);
                end else if (r_op == OP_DEC && r_found) begin
                    w_cmd = C_DEC;
                end
            end
            default: ;
        endcase
    end

    logic w_inwin;
    assign w_inwin = (w_cmd == C_INSERT) ? w_ins_inwin : w_upd_inwin;

    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
        localparam int unsigned LO = (g == 0) ? 0 : g - 1;
        localparam int unsigned HI = (g == MAX_ROWS - 1) ? g : g + 1;
        tsrb_cell #(.COLS(MAX_COLUMNS), .CW(CW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_sel       (w_sel[g]),
            .i_ins_here  (w_ins_here[g]),
            .i_ins_shift (w_ins_shift[g]),
            .i_rm_shift  (w_rm_shift[g]),
            .i_in_window (w_inwin),
            .i_key       (r_key),
            .i_col       (CW'(r_col)),
            .i_val       (r_val),
            .i_lo_key    (w_key[LO]),
            .i_lo_vals   (w_vals[LO]),
            .i_lo_vld    (w_vld[LO]),
            .i_lo_cnt    (w_cnt[LO]),
            .i_lo_upd    (w_upd[LO]),
            .i_hi_key    (w_key[HI]),
            .i_hi_vals   (w_vals[HI]),
            .i_hi_vld    (w_vld[HI]),
            .i_hi_cnt    (w_cnt[HI]),
            .i_hi_upd    (w_upd[HI]),
            .o_key       (w_key[g]),
            .o_vals      (w_vals[g]),
            .o_vld       (w_vld[g]),
            .o_cnt       (w_cnt[g]),
            .o_upd       (w_upd[g]),
            .o_match     (w_match[g])
        );
    end

    // row count update
    always_comb begin
        n_rows = r_rows;
        if (w_cmd == C_INSERT) n_rows = r_rows + RW'(1);
        else if (w_cmd == C_REMOVE) n_rows = r_rows - RW'(1);
    end

    assign i_cmd.ready = (r_st == S_IDLE);
    assign o_res.valid = r_o_vld;
    assign o_res.data.status       = r_o_status;
    assign o_res.data.new_entry    = r_o_new;
    assign o_res.data.out_column   = r_o_col;
    assign o_res.data.out_value    = r_o_val;
    assign o_res.data.out_valid    = r_o_valid;
    assign o_res.data.update_count = r_o_upd;
    assign o_res.data.row_count    = 7'(n_rows);
    assign o_res.data.last         = r_o_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_rows  <= '0;
            r_o_vld <= 1'b0;
            r_ev_on <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_rows <= n_rows;
            if (r_st == S_APPLY) r_o_vld <= 1'b1;
            else if (out_fire && (r_o_last || r_st == S_EMIT)) r_o_vld <= 1'b0;
            // once eviction starts it runs through all leading zero-counter rows
            if (r_st != S_EVICT) r_ev_on <= 1'b0;
            else if (evicting) r_ev_on <= 1'b1;
        end
    end

    // operation latch, search and result formation
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_cmd.valid) begin
            r_op  <= i_cmd.data.opcode;
            r_key <= i_cmd.data.timestamp;
            r_col <= i_cmd.data.column;
            r_val <= i_cmd.data.value;
        end
        if (r_st == S_EVICT) begin
            r_hit   <= w_hit;
            r_found <= w_found;
            r_fidx  <= w_fidx;
            r_pos   <= w_pos;
        end
        if (r_st == S_APPLY) begin
            r_o_new   <= 1'b0;
            r_o_col   <= '0;
            r_o_val   <= '0;
            r_o_valid <= 1'b0;
            r_o_upd   <= '0;
            r_o_last  <= 1'b1;
            r_o_status <= ST_OK;
            r_rcol    <= 8'd0;
            case (r_op)
                OP_WRITE: begin
                    if ({5'd0, r_col} >= eff_cols) r_o_status <= ST_BADCOL;
                    else if (r_found) r_o_upd <= (w_upd[r_fidx] == 16'hFFFF) ?
                                                 16'hFFFF : w_upd[r_fidx] + 16'd1;
                    else if (!ins_ok) r_o_status <= ST_FULL;
                    else begin
                        r_o_new <= 1'b1;
                        r_o_upd <= 16'd1;
                    end
                end
                OP_DELETE, OP_DEC, OP_QUERY: begin
                    if (!r_found) r_o_status <= ST_NOKEY;
                    else if (r_op != OP_DELETE) r_o_upd <= w_upd[r_fidx];
                end
                OP_READ: begin
                    if (!r_found) r_o_status <= ST_NOKEY;
                    else begin
                        r_o_upd   <= w_upd[r_fidx];
                        r_o_valid <= w_vld[r_fidx][0];
                        r_o_val   <= w_vld[r_fidx][0] ? w_vals[r_fidx][0] : 64'd0;
                        r_o_last  <= (eff_cols == 8'd1);
                        r_rcol    <= 8'd1;
                    end
                end
                default: ;
            endcase
        end else if (r_st == S_READ && out_fire && !r_o_last) begin
            r_o_col   <= r_rcol[2:0];
            r_o_valid <= w_vld[r_fidx][CW'(r_rcol)];
            r_o_val   <= w_vld[r_fidx][CW'(r_rcol)] ? w_vals[r_fidx][CW'(r_rcol)] : 64'd0;
            r_o_last  <= (r_rcol + 8'd1 == eff_cols);
            r_rcol    <= r_rcol + 8'd1;
        end
    end

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_rows <= RW'(MAX_ROWS))
        else $error("row count exceeds capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == C_INSERT) |-> (r_rows < cap))
        else $error("insert into a full table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !o_res.valid)
        else $error("new word taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_APPLY) |-> $onehot0(r_hit))
        else $error("key matched in more than one row");
endmodule

// ----- tb/timestamp_sorted_record_buffer_tb.sv -----
// Testbench: self-checking random and directed test of the sorted record buffer
`timescale 1ns / 1ps

module timestamp_sorted_record_buffer_tb;
    import tsrb_pkg::*;

    localparam int unsigned ROWS = 64;
    localparam int unsigned COLS = 8;
    localparam int unsigned FACTOR = 2;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] timestamp;
        logic [2:0]  column;
        logic [63:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        new_entry;
        logic [2:0]  out_column;
        logic [63:0] out_value;
        logic        out_valid;
        logic [15:0] update_count;
        logic [6:0]  row_count;
        logic        last;
    } t_res_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [5:0] i_cfg_data;

    tsrb_if #(.T(t_cmd_word)) cmd_ch ();
    tsrb_if #(.T(t_res_word)) res_ch ();

    timestamp_sorted_record_buffer #(
        .MAX_ROWS(ROWS),
        .MAX_COLUMNS(COLS),
        .LENGTH_FACTOR(FACTOR)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd(cmd_ch.sink),
        .o_res(res_ch.source)
    );

    // Clock: 2 ns period
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Mirror of the table
    logic signed [63:0] tbl_keys [ROWS];
    logic [63:0] tbl_vals [ROWS][COLS];
    logic        tbl_vld [ROWS][COLS];
    logic [3:0]  tbl_cnt [ROWS];
    logic [15:0] tbl_upd [ROWS];
    int unsigned tbl_held;
    logic [3:0]  mir_cols;
    logic [5:0]  mir_win;

    t_res_word expected_q[$];
    int unsigned mismatches;
    bit no_idle;
    int unsigned quiet_cycles;

    function automatic int unsigned cols_in_use();
        if (mir_cols == 0) return 1;
        if (mir_cols > COLS) return COLS;
        return mir_cols;
    endfunction

    function automatic int unsigned win_rows();
        return (mir_win == 0) ? 1 : mir_win;
    endfunction

    function automatic int unsigned table_cap();
        int unsigned c;
        c = FACTOR * win_rows();
        return (c > ROWS) ? ROWS : c;
    endfunction

    function automatic bit counted(int unsigned r);
        return (r + win_rows() >= tbl_held);
    endfunction

    function automatic int find_key(logic signed [63:0] k);
        for (int r = 0; r < int'(tbl_held); r++)
            if (tbl_keys[r] == k) return r;
        return -1;
    endfunction

    function automatic void move_row(int unsigned dst, int unsigned src);
        tbl_keys[dst] = tbl_keys[src];
        tbl_cnt[dst] = tbl_cnt[src];
        tbl_upd[dst] = tbl_upd[src];
        for (int c = 0; c < COLS; c++) begin
            tbl_vals[dst][c] = tbl_vals[src][c];
            tbl_vld[dst][c] = tbl_vld[src][c];
        end
    endfunction

    function automatic void drop_rows(int unsigned at, int unsigned n);
        for (int unsigned r = at; r + n < tbl_held; r++) move_row(r, r + n);
        tbl_held -= n;
    endfunction

    function automatic void push_result(logic [1:0] st, logic ne, logic [2:0] col,
                                        logic [63:0] val, logic v, logic [15:0] upd,
                                        logic lst);
        t_res_word w;
        w.status = st;
        w.new_entry = ne;
        w.out_column = col;
        w.out_value = val;
        w.out_valid = v;
        w.update_count = upd;
        w.row_count = tbl_held[6:0];
        w.last = lst;
        expected_q = {expected_q, w};
    endfunction

    // Write: update in place, or evict/insert in sorted position
    function automatic void apply_write(logic signed [63:0] k, logic [2:0] col,
                                        logic [63:0] val);
        int f;
        int unsigned z;
        int unsigned pos;
        if (col >= cols_in_use()) begin
            push_result(ST_BADCOL, 0, 0, 0, 0, 0, 1);
            return;
        end
        f = find_key(k);
        if (f >= 0) begin
            if (!tbl_vld[f][col] && counted(f) && tbl_cnt[f] < 15) tbl_cnt[f]++;
            tbl_vals[f][col] = val;
            tbl_vld[f][col] = 1;
            if (tbl_upd[f] != 16'hFFFF) tbl_upd[f]++;
            push_result(ST_OK, 0, 0, 0, 0, tbl_upd[f], 1);
            return;
        end
        if (tbl_held >= table_cap()) begin
            z = 0;
            while (z < tbl_held && tbl_cnt[z] == 0) z++;
            if (z > 0) drop_rows(0, z);
            if (tbl_held >= table_cap()) begin
                push_result(ST_FULL, 0, 0, 0, 0, 0, 1);
                return;
            end
        end
        pos = 0;
        while (pos < tbl_held && !(k < tbl_keys[pos])) pos++;
        for (int unsigned r = tbl_held; r > pos; r--) move_row(r, r - 1);
        tbl_held++;
        tbl_keys[pos] = k;
        for (int c = 0; c < COLS; c++) begin
            tbl_vals[pos][c] = 0;
            tbl_vld[pos][c] = 0;
        end
        tbl_vals[pos][col] = val;
        tbl_vld[pos][col] = 1;
        tbl_cnt[pos] = counted(pos) ? 4'd1 : 4'd0;
        tbl_upd[pos] = 1;
        push_result(ST_OK, 1, 0, 0, 0, 1, 1);
    endfunction

    // Expected result words for one accepted command word
    function automatic void predict_results(t_cmd_word w);
        int f;
        int unsigned nc;
        logic signed [63:0] k;
        k = w.timestamp;
        if (w.opcode == OP_WRITE) begin
            apply_write(k, w.column, w.value);
        end else if (w.opcode > OP_QUERY) begin
            push_result(ST_OK, 0, 0, 0, 0, 0, 1);
        end else begin
            f = find_key(k);
            if (f < 0) begin
                push_result(ST_NOKEY, 0, 0, 0, 0, 0, 1);
            end else if (w.opcode == OP_DELETE) begin
                drop_rows(f, 1);
                push_result(ST_OK, 0, 0, 0, 0, 0, 1);
            end else if (w.opcode == OP_READ) begin
                nc = cols_in_use();
                for (int unsigned c = 0; c < nc; c++)
                    push_result(ST_OK, 0, c[2:0], tbl_vld[f][c] ? tbl_vals[f][c] : 64'd0,
                                tbl_vld[f][c], tbl_upd[f], c == nc - 1);
            end else begin
                if (w.opcode == OP_DEC && tbl_cnt[f] > 0) tbl_cnt[f]--;
                push_result(ST_OK, 0, 0, 0, 0, tbl_upd[f], 1);
            end
        end
    endfunction

    // Send one command word, with a random gap before it unless no_idle is set
    task automatic send_op(logic [2:0] op, logic [63:0] ts, logic [2:0] col,
                           logic [63:0] val);
        t_cmd_word w;
        w.opcode = op;
        w.timestamp = ts;
        w.column = col;
        w.value = val;
        if (!no_idle) begin
            while ($urandom_range(99) < 24) begin
                cmd_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= w;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_results(w);
    endtask

    // Wait until every expected word has come and the block has settled
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(int unsigned idx, logic [5:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx[0:0];
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_NUM_COLUMNS) mir_cols = data[3:0];
        else mir_win = data;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Receiver: random back-pressure, none while no_idle is set
    always @(posedge i_clk) begin
        res_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            t_res_word got;
            t_res_word exp_w;
            got = res_ch.data;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
                exp_w = expected_q.pop_front();
                if (got.status !== exp_w.status || got.new_entry !== exp_w.new_entry ||
                    got.out_column !== exp_w.out_column ||
                    got.out_value !== exp_w.out_value ||
                    got.out_valid !== exp_w.out_valid ||
                    got.update_count !== exp_w.update_count ||
                    got.row_count !== exp_w.row_count || got.last !== exp_w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_w, got);
                end
            end
        end
    end

    // Watchdog: cycles with no word moved on either side
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Extremes of keys and values, every opcode, missing keys, unused opcodes
    task automatic test_directed();
        send_op(OP_WRITE, 64'h8000_0000_0000_0000, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(OP_WRITE, 64'h7FFF_FFFF_FFFF_FFFF, 3'd7, 64'h0);
        send_op(OP_WRITE, 64'h0, 3'd3, 64'hA5A5_5A5A_0F0F_F0F0);
        send_op(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 3'd5, 64'h1);
        send_op(OP_WRITE, 64'h8000_0000_0000_0000, 3'd7, 64'h8000_0000_0000_0001);
        send_op(OP_WRITE, 64'h8000_0000_0000_0000, 3'd7, 64'h5);
        send_op(OP_READ, 64'h8000_0000_0000_0000, 3'd0, 64'h0);
        send_op(OP_READ, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 64'h0);
        send_op(OP_READ, 64'h1234, 3'd0, 64'h0);
        send_op(OP_QUERY, 64'h7FFF_FFFF_FFFF_FFFF, 3'd0, 64'h0);
        send_op(OP_QUERY, 64'h55, 3'd0, 64'h0);
        send_op(OP_DEC, 64'h0, 3'd0, 64'h0);
        send_op(OP_DEC, 64'h0, 3'd0, 64'h0);
        send_op(OP_DEC, 64'h77, 3'd0, 64'h0);
        send_op(OP_DELETE, 64'h0, 3'd0, 64'h0);
        send_op(OP_DELETE, 64'h0, 3'd0, 64'h0);
        send_op(3'd5, 64'h7FFF_FFFF_FFFF_FFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(3'd7, 64'h0, 3'd0, 64'h0);
        send_op(OP_READ, 64'h7FFF_FFFF_FFFF_FFFF, 3'd0, 64'h0);
    endtask

    // Small window: fill, a bad column, evict zero-counter rows, then update and read a row
    task automatic test_eviction();
        set_reg(REG_NUM_COLUMNS, 6'd3);
        set_reg(REG_WINDOW_SIZE, 6'd2);
        for (int i = 0; i < 4; i++) send_op(OP_WRITE, 64'(i * 10), 3'd1, rand64());
        send_op(OP_WRITE, 64'd5, 3'd3, 64'h9);
        send_op(OP_DEC, 64'd0, 3'd0, 64'h0);
        send_op(OP_DEC, 64'd10, 3'd0, 64'h0);
        send_op(OP_WRITE, 64'd25, 3'd2, rand64());
        send_op(OP_WRITE, 64'd35, 3'd0, rand64());
        send_op(OP_WRITE, 64'd20, 3'd2, rand64());
        send_op(OP_READ, 64'd20, 3'd0, 64'h0);
    endtask

    // Random operations over a small key pool, with some wide keys
    task automatic test_random(int unsigned n);
        logic [2:0] op;
        logic [63:0] ts;
        int unsigned pick;
        for (int unsigned i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) op = OP_WRITE;
            else if (pick < 60) op = OP_READ;
            else if (pick < 72) op = OP_DEC;
            else if (pick < 82) op = OP_DELETE;
            else if (pick < 95) op = OP_QUERY;
            else op = 3'($urandom_range(7));
            if ($urandom_range(9) == 0) ts = rand64();
            else ts = 64'($signed($urandom_range(11)) - 6);
            send_op(op, ts, 3'($urandom_range(7)), rand64());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        no_idle = 0;
        mismatches = 0;
        quiet_cycles = 0;
        tbl_held = 0;
        mir_cols = 4'd8;
        mir_win = 6'd32;
        for (int r = 0; r < ROWS; r++) begin
            tbl_cnt[r] = 0;
            tbl_upd[r] = 0;
            tbl_keys[r] = 0;
            for (int c = 0; c < COLS; c++) begin
                tbl_vals[r][c] = 0;
                tbl_vld[r][c] = 0;
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_eviction();
        test_random(30);
        set_reg(REG_NUM_COLUMNS, 6'd1);
        set_reg(REG_WINDOW_SIZE, 6'd1);
        test_random(25);
        no_idle = 1;
        set_reg(REG_NUM_COLUMNS, 6'd15);
        set_reg(REG_WINDOW_SIZE, 6'd63);
        test_random(35);
        no_idle = 0;
        set_reg(REG_NUM_COLUMNS, 6'd0);
        set_reg(REG_WINDOW_SIZE, 6'd0);
        test_random(25);
        set_reg(REG_NUM_COLUMNS, 6'd8);
        set_reg(REG_WINDOW_SIZE, 6'd4);
        test_random(35);
        drain();

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tsrb_pkg.sv
sv/tsrb_if.sv
sv/tsrb_cell.sv
sv/timestamp_sorted_record_buffer.sv
tb/timestamp_sorted_record_buffer_tb.sv
